// ----- hdl/lfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU frame replacer package
// Sizes, request codes and the control bundle shared by the list cells.
// ----------------------------------------------------------------------------
package lfr_pkg;

   localparam int LIST_DEPTH  = 64;
   localparam int FRAME_COUNT = 1024;

   localparam int REQ_W   = 2;
   localparam int FRAME_W = 10;
   localparam int CAP_W   = 7;
   localparam int IDX_W   = $clog2(LIST_DEPTH);
   localparam int CNT_W   = $clog2(LIST_DEPTH + 1);

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   localparam logic [REQ_W-1:0] REQ_VICTIM = 2'd0;
   localparam logic [REQ_W-1:0] REQ_PIN    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_UNPIN  = 2'd2;

   // broadcast from the sequencer to every cell of the list
   typedef struct packed {
      logic [CNT_W-1:0]   length;
      logic [FRAME_W-1:0] frame;
      logic               compare_en;
      logic               shift_en;
      logic [IDX_W-1:0]   shift_pos;
      logic               write_en;
      logic [IDX_W-1:0]   write_pos;
   } cell_ctrl_type;

endpackage

// ----- hdl/lfr_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU list cell
// One slot of the ordered list: holds a frame id, compares it with the
// request frame and takes its younger neighbor's id when the list closes up.
// ----------------------------------------------------------------------------
module lfr_cell (
   input  logic                         clock,
   input  logic [lfr_pkg::IDX_W-1:0]    index,
   input  lfr_pkg::cell_ctrl_type       ctrl,
   input  logic [lfr_pkg::FRAME_W-1:0]  next_frame,
   output logic [lfr_pkg::FRAME_W-1:0]  frame,
   output logic                         match
);
   import lfr_pkg::*;

   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               match_ff, match_in;
   logic               valid;

   assign valid = CNT_W'(index) < ctrl.length;

   always_comb begin
      frame_in = frame_ff;
      if (ctrl.write_en && ctrl.write_pos == index) begin
         frame_in = ctrl.frame;
      end else if (ctrl.shift_en && index >= ctrl.shift_pos) begin
         frame_in = next_frame;
      end
   end

   always_comb begin
      match_in = match_ff;
      if (ctrl.compare_en) begin
         match_in = valid && (frame_ff == ctrl.frame);
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      match_ff <= match_in;
   end

   assign frame = frame_ff;
   assign match = match_ff;

endmodule

// ----- hdl/lru_frame_replacer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU frame replacer
// Ordered list of evictable frame ids (oldest first) held in a chain of cells;
// victim, pin and unpin requests, each answered with one response.
// ----------------------------------------------------------------------------
//  channel  direction  payload (low bit first)
//  req_     in         req_type[1:0], frame_number[11:2], zero pad to 16
//  rsp_     out        victim_found[0], victim_frame[10:1], entry_count[17:11],
//                      zero pad to 24
//  csr_     in         capacity_limit[6:0]
//
//  Two steps per request: the accept edge runs the compare in every cell, and
//  the edge leaving seek finds the hit, shifts the cells, loads the response.
//  One request is in flight at a time; req_tready is high only in idle.
//  A response held by rsp_tready low stalls the second step, no data is lost.
//  Reset (synchronous, active high) empties the list and sets the limit to 64;
//  the cell contents are not cleared, only the length.
// ----------------------------------------------------------------------------
module lru_frame_replacer (
   input  logic        clock,
   input  logic        reset,
   // request: req_type[1:0], frame_number[11:2]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // response: victim_found[0], victim_frame[10:1], entry_count[17:11]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // capacity limit write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);
   import lfr_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SEEK = 1'b1;

   logic               state_ff, state_in;
   logic [CNT_W-1:0]   length_ff, length_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [REQ_W-1:0]   req_type_ff, req_type_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_data_ff, rsp_data_in;

   logic               accept, go;
   logic [CNT_W-1:0]   limit;
   logic               any_match;
   logic [IDX_W-1:0]   hit_pos;
   logic               found;
   logic [FRAME_W-1:0] vframe;
   cell_ctrl_type      ctrl;

   logic [FRAME_W-1:0] cell_frame [LIST_DEPTH];
   logic [FRAME_W-1:0] cell_next  [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] cell_match;

   // nothing is taken while reset is held
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;
   // second step proceeds once the response register is free
   assign go         = (state_ff == S_SEEK) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = !reset;

   // effective limit: zero acts as one, above depth acts as depth
   always_comb begin
      if (cap_ff == '0) begin
         limit = CNT_W'(1);
      end else if (int'(cap_ff) > LIST_DEPTH) begin
         limit = CNT_W'(LIST_DEPTH);
      end else begin
         limit = CNT_W'(cap_ff);
      end
   end

   // list entries are unique, so at most one cell hits; OR-encode its index
   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (cell_match[i]) begin
            hit_pos = hit_pos | IDX_W'(i);
         end
      end
   end
   assign any_match = |cell_match;

   // sequencer: decide shift / append for the cells and the new length
   always_comb begin
      ctrl.length     = length_ff;
      ctrl.frame      = accept ? req_tdata[REQ_W +: FRAME_W] : frame_ff;
      ctrl.compare_en = accept;
      ctrl.shift_en   = 1'b0;
      ctrl.shift_pos  = '0;
      ctrl.write_en   = 1'b0;
      ctrl.write_pos  = '0;
      length_in       = length_ff;
      found           = 1'b0;
      vframe          = '0;
      if (go) begin
         case (req_type_ff)
            REQ_VICTIM: begin
               if (length_ff != '0) begin
                  found         = 1'b1;
                  vframe        = cell_frame[0];
                  ctrl.shift_en = 1'b1;
                  length_in     = length_ff - 1'b1;
               end
            end
            REQ_PIN: begin
               if (int'(frame_ff) < FRAME_COUNT && any_match) begin
                  ctrl.shift_en  = 1'b1;
                  ctrl.shift_pos = hit_pos;
                  length_in      = length_ff - 1'b1;
               end
            end
            REQ_UNPIN: begin
               if (int'(frame_ff) < FRAME_COUNT && !any_match) begin
                  if (length_ff >= limit && length_ff != '0) begin
                     // full: drop the oldest, append at the young end
                     ctrl.shift_en  = 1'b1;
                     ctrl.write_en  = 1'b1;
                     ctrl.write_pos = IDX_W'(length_ff - 1'b1);
                  end else if (int'(length_ff) < LIST_DEPTH) begin
                     ctrl.write_en  = 1'b1;
                     ctrl.write_pos = IDX_W'(length_ff);
                     length_in      = length_ff + 1'b1;
                  end
               end
            end
            default: begin
               // unused code: no change
            end
         endcase
      end
   end

   // cell chain: each cell takes its younger neighbor's frame on a shift
   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      if (g == LIST_DEPTH - 1) begin : g_tail
         assign cell_next[g] = '0;
      end else begin : g_link
         assign cell_next[g] = cell_frame[g+1];
      end
      lfr_cell u_cell (
         .clock      (clock),
         .index      (IDX_W'(g)),
         .ctrl       (ctrl),
         .next_frame (cell_next[g]),
         .frame      (cell_frame[g]),
         .match      (cell_match[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      req_type_in  = req_type_ff;
      frame_in     = frame_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cap_in       = csr_valid ? csr_data : cap_ff;
      if (accept) begin
         state_in    = S_SEEK;
         req_type_in = req_tdata[REQ_W-1:0];
         frame_in    = req_tdata[REQ_W +: FRAME_W];
      end
      if (go) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, length_in, vframe, found};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         length_ff    <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff <= req_type_in;
      frame_ff    <= frame_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // unique entries: never more than one hit when the hit is used
   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEEK) |-> $onehot0(cell_match))
      else $error("more than one cell matched the request frame");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      int'(length_ff) <= LIST_DEPTH)
      else $error("list length beyond depth");

   a_accept_seek: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_SEEK))
      else $error("accepted request did not enter the seek step");

   a_len_step: assert property (@(posedge clock) disable iff (reset)
      go |=> (length_ff == $past(length_ff) || length_ff == $past(length_ff) + 1'b1
              || length_ff == $past(length_ff) - 1'b1))
      else $error("list length changed by more than one");

endmodule
